### rtl/core/fbdc_pkg.sv
// fbdc_pkg: shared types and constants of the four-button debounce classifier
// no dependencies; used by the channel interfaces, fbdc_eval and the top level

package fbdc_pkg;

  localparam int NUM_BUTTONS    = 4;
  localparam int BACK_BUTTON    = 3;
  localparam int LEVEL_WIDTH    = 4;
  localparam int NOW_WIDTH      = 32;
  localparam int EVENT_WIDTH    = 3;
  localparam int CFG_WIDTH      = 16;
  localparam int CFG_IDX_WIDTH  = 1;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG_PRESS = 1'd1;

  typedef enum logic [EVENT_WIDTH-1:0] {
    EV_NONE       = 3'd0,
    EV_UP_SHORT   = 3'd1,
    EV_DOWN_SHORT = 3'd2,
    EV_OK_SHORT   = 3'd3,
    EV_BACK_SHORT = 3'd4,
    EV_BACK_LONG  = 3'd5,
    EV_ANY        = 3'd6
  } event_t;

  // short event of each button, indexed by button number
  localparam event_t SHORT_EVENT [NUM_BUTTONS] = '{
    EV_UP_SHORT, EV_DOWN_SHORT, EV_OK_SHORT, EV_BACK_SHORT
  };

  // state changes and result of one scan
  typedef struct packed {
    logic [NUM_BUTTONS-1:0] press_set;
    logic [NUM_BUTTONS-1:0] release_clr;
    logic                   stamp_all;
    event_t                 event_code;
  } update_t;

endpackage

### rtl/core/fbdc_channels.sv
// fbdc_scan_if and fbdc_event_if: valid/ready channels of the classifier
// depends on fbdc_pkg for field widths

interface fbdc_scan_if;
  logic                             valid;
  logic                             ready;
  logic [fbdc_pkg::LEVEL_WIDTH-1:0] levels;
  logic [fbdc_pkg::NOW_WIDTH-1:0]   now_ms;

  modport source (output valid, output levels, output now_ms, input ready);
  modport sink   (input valid, input levels, input now_ms, output ready);
endinterface

interface fbdc_event_if;
  logic                             valid;
  logic                             ready;
  logic [fbdc_pkg::EVENT_WIDTH-1:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink   (input valid, input event_res, output ready);
endinterface

### rtl/core/fbdc_eval.sv
// fbdc_eval: combinational classification of one scan against button state
// depends on fbdc_pkg for update_t, event codes and button count

module fbdc_eval #(
  parameter int TIME_BITS = 32
) (
  input  logic [fbdc_pkg::LEVEL_WIDTH-1:0]                  levels,
  input  logic [TIME_BITS-1:0]                              now,
  input  logic [fbdc_pkg::NUM_BUTTONS-1:0]                  held,
  input  logic [fbdc_pkg::NUM_BUTTONS-1:0][TIME_BITS-1:0]   release_stamp,
  input  logic [TIME_BITS-1:0]                              back_press_stamp,
  input  logic [fbdc_pkg::CFG_WIDTH-1:0]                    debounce_time,
  input  logic [fbdc_pkg::CFG_WIDTH-1:0]                    long_press_time,
  output fbdc_pkg::update_t                                 upd
);

  logic [fbdc_pkg::NUM_BUTTONS-1:0] low;
  logic [fbdc_pkg::NUM_BUTTONS-1:0] settled;
  logic [TIME_BITS-1:0]             since_release [fbdc_pkg::NUM_BUTTONS];
  logic [TIME_BITS-1:0]             hold_time;
  logic                             is_long;

  always_comb begin
    for (int i = 0; i < fbdc_pkg::NUM_BUTTONS; i++) begin
      low[i]           = ~levels[i];
      since_release[i] = now - release_stamp[i];
      settled[i]       = since_release[i] > TIME_BITS'(debounce_time);
    end
  end

  assign hold_time = now - back_press_stamp;
  assign is_long   = hold_time >= TIME_BITS'(long_press_time);

  always_comb begin
    logic found;
    found           = 1'b0;
    upd.press_set   = '0;
    upd.release_clr = '0;
    upd.stamp_all   = 1'b0;
    upd.event_code  = fbdc_pkg::EV_NONE;
    // first pass stops at the lowest released button
    for (int i = 0; i < fbdc_pkg::NUM_BUTTONS; i++) begin
      if (!found) begin
        upd.press_set[i] = low[i] && !held[i] && settled[i];
        if (!low[i] && held[i]) begin
          found              = 1'b1;
          upd.release_clr[i] = 1'b1;
          if (i == fbdc_pkg::BACK_BUTTON && is_long) begin
            upd.event_code = fbdc_pkg::EV_BACK_LONG;
          end else begin
            upd.event_code = fbdc_pkg::SHORT_EVENT[i];
          end
        end
      end
    end
    // second pass uses release stamps as they were before this scan
    if (!found && |(low & settled)) begin
      upd.stamp_all  = 1'b1;
      upd.event_code = fbdc_pkg::EV_ANY;
    end
  end

endmodule

### rtl/core/four_button_debounce_classifier_core.sv
// four_button_debounce_classifier_core: top level of the button classifier
// depends on fbdc_pkg, fbdc_scan_if, fbdc_event_if and fbdc_eval
//
// Usage:
//   scan  (sink)   one item per scan: levels (bit i low = button i pressed) and
//                  now_ms, a free-running millisecond count
//   evt   (source) exactly one item per scan: event_res, 0 when nothing happened
//   cfg_we/cfg_index/cfg_data write debounce_time (index 0) or long_press_time
//   (index 1); write only while no scan is in flight
// Timing:
//   a scan is registered on acceptance and classified against the per-button
//   state from the stage register; its event lands in the output register,
//   which drives evt.valid, at the same edge as the state update, both
//   waiting while the output register holds an untaken event; one scan is
//   taken per cycle while evt.ready keeps the output register moving
// Reset (rst, synchronous): all buttons idle, all time stamps zero,
//   debounce_time 50, long_press_time 1000, both stages empty
// Stalls: while evt.ready is low the event waits in the output register; the
//   scan register still fills, then scan.ready drops until the event is taken
// Time stamps are TIME_BITS wide and elapsed times wrap modulo 2^TIME_BITS

module four_button_debounce_classifier_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fbdc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [fbdc_pkg::CFG_WIDTH-1:0]      cfg_data,
  fbdc_scan_if.sink                           scan,
  fbdc_event_if.source                        evt
);

  logic [fbdc_pkg::CFG_WIDTH-1:0] debounce_time;
  logic [fbdc_pkg::CFG_WIDTH-1:0] long_press_time;

  logic                                          stg_vld;
  logic [fbdc_pkg::LEVEL_WIDTH-1:0]              stg_levels;
  logic [TIME_BITS-1:0]                          stg_now;
  logic [TIME_BITS-1:0]                          scan_now;

  logic [fbdc_pkg::NUM_BUTTONS-1:0]                held;
  logic [fbdc_pkg::NUM_BUTTONS-1:0][TIME_BITS-1:0] release_stamp;
  logic [fbdc_pkg::NUM_BUTTONS-1:0][TIME_BITS-1:0] press_stamp;

  logic                              out_vld;
  logic [fbdc_pkg::EVENT_WIDTH-1:0]  out_event;

  logic                              advance;
  logic                              commit;
  logic [fbdc_pkg::NUM_BUTTONS-1:0]  stamp_mask;
  fbdc_pkg::update_t                 upd;

  // fit the 32-bit timestamp to the stored time width
  generate
    if (TIME_BITS <= fbdc_pkg::NOW_WIDTH) begin : g_now_trunc
      assign scan_now = scan.now_ms[TIME_BITS-1:0];
    end else begin : g_now_ext
      assign scan_now = {{(TIME_BITS - fbdc_pkg::NOW_WIDTH){1'b0}}, scan.now_ms};
    end
  endgenerate

  assign advance    = !out_vld || evt.ready;
  assign commit     = advance && stg_vld;
  assign scan.ready = !stg_vld || advance;
  assign stamp_mask = upd.release_clr | {fbdc_pkg::NUM_BUTTONS{upd.stamp_all}};

  assign evt.valid     = out_vld;
  assign evt.event_res = out_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= fbdc_pkg::DEBOUNCE_RESET;
      long_press_time <= fbdc_pkg::LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fbdc_pkg::REG_DEBOUNCE:   debounce_time   <= cfg_data;
        fbdc_pkg::REG_LONG_PRESS: long_press_time <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= 1'b0;
    end else if (scan.ready) begin
      stg_vld <= scan.valid;
    end
    if (scan.valid && scan.ready) begin
      stg_levels <= scan.levels;
      stg_now    <= scan_now;
    end
  end

  fbdc_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .levels           (stg_levels),
    .now              (stg_now),
    .held             (held),
    .release_stamp    (release_stamp),
    .back_press_stamp (press_stamp[fbdc_pkg::BACK_BUTTON]),
    .debounce_time    (debounce_time),
    .long_press_time  (long_press_time),
    .upd              (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= '0;
      release_stamp <= '0;
      press_stamp   <= '0;
    end else if (commit) begin
      held <= (held | upd.press_set) & ~upd.release_clr;
      for (int i = 0; i < fbdc_pkg::NUM_BUTTONS; i++) begin
        if (upd.press_set[i]) begin
          press_stamp[i] <= stg_now;
        end
        if (stamp_mask[i]) begin
          release_stamp[i] <= stg_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= stg_vld;
    end
    if (commit) begin
      out_event <= upd.event_code;
    end
  end

  // at most one release handled per scan
  a_single_release: assert property (@(posedge clk) disable iff (rst)
    $onehot0(upd.release_clr))
    else $error("more than one button released in one scan");

  // any-pressed only when no release was handled
  a_any_excl: assert property (@(posedge clk) disable iff (rst)
    upd.stamp_all |-> (upd.release_clr == '0))
    else $error("any-pressed together with a release");

  // a press only starts on an idle button
  a_press_idle: assert property (@(posedge clk) disable iff (rst)
    (upd.press_set & held) == '0)
    else $error("press started on a held button");

  // a committed release leaves that button idle
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    commit && (upd.release_clr != '0) |=> (held & $past(upd.release_clr)) == '0)
    else $error("released button still held");

  // an accepted scan is in the stage register next cycle
  a_scan_staged: assert property (@(posedge clk) disable iff (rst)
    scan.valid && scan.ready |=> stg_vld)
    else $error("accepted scan lost");

endmodule

### test/four_button_debounce_classifier_core_tb.sv
// four_button_debounce_classifier_core_tb: self-checking bench for the button classifier
// drives scans with random gaps, predicts each event in the bench and compares it in order
// depends on fbdc_pkg, fbdc_scan_if, fbdc_event_if and four_button_debounce_classifier_core

module four_button_debounce_classifier_core_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_SCANS  = 305;

  typedef struct packed {
    logic [fbdc_pkg::LEVEL_WIDTH-1:0] levels;
    logic [fbdc_pkg::NOW_WIDTH-1:0]   now_ms;
  } scan_item_t;

  logic clk = 1'b0;
  logic rst;
  logic                               cfg_we;
  logic [fbdc_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
  logic [fbdc_pkg::CFG_WIDTH-1:0]     cfg_data;

  fbdc_scan_if  scan_ch ();
  fbdc_event_if evt_ch ();

  four_button_debounce_classifier_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan      (scan_ch),
    .evt       (evt_ch)
  );

  always #5 clk = ~clk;

  // bench copy of the classifier state and registers
  logic                           btn_held  [fbdc_pkg::NUM_BUTTONS];
  logic [fbdc_pkg::NOW_WIDTH-1:0] rel_stamp [fbdc_pkg::NUM_BUTTONS];
  logic [fbdc_pkg::NOW_WIDTH-1:0] prs_stamp [fbdc_pkg::NUM_BUTTONS];
  logic [fbdc_pkg::CFG_WIDTH-1:0] debounce_ms;
  logic [fbdc_pkg::CFG_WIDTH-1:0] long_press_ms;

  scan_item_t       scan_q [$];
  fbdc_pkg::event_t pending_events [$];

  int  scans_sent;
  int  events_checked;
  int  mismatches;
  int  settings_used;
  int  cycle_cnt;
  int  event_count [7];
  int  send_gap;
  int  send_calm;
  int  recv_stall;
  int  recv_calm;
  int  recv_draw;
  logic scan_took;
  logic evt_took;

  // generator state: levels as driven, time, and when each level last changed
  logic [fbdc_pkg::LEVEL_WIDTH-1:0] gen_lv;
  logic [fbdc_pkg::NOW_WIDTH-1:0]   gen_now;
  logic [fbdc_pkg::NOW_WIDTH-1:0]   gen_edge [fbdc_pkg::NUM_BUTTONS];

  function automatic fbdc_pkg::event_t classify_scan(logic [fbdc_pkg::LEVEL_WIDTH-1:0] lv,
                                                     logic [fbdc_pkg::NOW_WIDTH-1:0] now);
    logic [fbdc_pkg::NOW_WIDTH-1:0] since;
    logic [fbdc_pkg::NOW_WIDTH-1:0] dur;
    // release pass, a low idle button may start a press on the way
    for (int b = 0; b < fbdc_pkg::NUM_BUTTONS; b++) begin
      since = now - rel_stamp[b];
      if (!lv[b] && !btn_held[b] && since > {16'd0, debounce_ms}) begin
        btn_held[b]  = 1'b1;
        prs_stamp[b] = now;
      end
      if (lv[b] && btn_held[b]) begin
        dur          = now - prs_stamp[b];
        btn_held[b]  = 1'b0;
        rel_stamp[b] = now;
        if (b == fbdc_pkg::BACK_BUTTON && dur >= {16'd0, long_press_ms})
          return fbdc_pkg::EV_BACK_LONG;
        return fbdc_pkg::SHORT_EVENT[b];
      end
    end
    for (int b = 0; b < fbdc_pkg::NUM_BUTTONS; b++) begin
      since = now - rel_stamp[b];
      if (!lv[b] && since > {16'd0, debounce_ms}) begin
        for (int j = 0; j < fbdc_pkg::NUM_BUTTONS; j++)
          rel_stamp[j] = now;
        return fbdc_pkg::EV_ANY;
      end
    end
    return fbdc_pkg::EV_NONE;
  endfunction

  // acceptance on both channels, result check first, then prediction
  always @(posedge clk) begin
    scan_took <= !rst && scan_ch.valid && scan_ch.ready;
    evt_took  <= !rst && evt_ch.valid && evt_ch.ready;
    if (rst) begin
      for (int b = 0; b < fbdc_pkg::NUM_BUTTONS; b++) begin
        btn_held[b]  = 1'b0;
        rel_stamp[b] = '0;
        prs_stamp[b] = '0;
      end
      debounce_ms   = fbdc_pkg::DEBOUNCE_RESET;
      long_press_ms = fbdc_pkg::LONG_PRESS_RESET;
    end else begin
      if (evt_ch.valid && evt_ch.ready) begin
        if (pending_events.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected event %0d at cycle %0d", evt_ch.event_res, cycle_cnt);
          mismatches++;
        end else begin
          if (evt_ch.event_res !== pending_events[0]) begin
            if (mismatches < 10)
              $display("event %0d mismatch: expected %0d (%s) got %0d", events_checked,
                       pending_events[0], pending_events[0].name(), evt_ch.event_res);
            mismatches++;
          end
          if (pending_events[0] <= fbdc_pkg::EV_ANY)
            event_count[pending_events[0]]++;
          void'(pending_events.pop_front());
          events_checked++;
        end
      end
      if (scan_ch.valid && scan_ch.ready) begin
        pending_events.push_back(classify_scan(scan_ch.levels, scan_ch.now_ms));
        scans_sent++;
      end
    end
  end

  // scan driver: holds an item until taken, then waits its drawn gap
  always @(negedge clk) begin
    if (rst) begin
      scan_ch.valid  <= 1'b0;
      scan_ch.levels <= '1;
      scan_ch.now_ms <= '0;
      send_gap       <= 0;
      send_calm      <= 0;
    end else if (!scan_ch.valid || scan_took) begin
      if (send_gap > 0) begin
        scan_ch.valid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (scan_q.size() == 0) begin
        scan_ch.valid <= 1'b0;
      end else begin
        scan_ch.valid  <= 1'b1;
        scan_ch.levels <= scan_q[0].levels;
        scan_ch.now_ms <= scan_q[0].now_ms;
        void'(scan_q.pop_front());
        if (send_calm > 0) begin
          send_gap  <= 0;
          send_calm <= send_calm - 1;
        end else begin
          send_gap <= $urandom_range(0, 17);
          if ($urandom_range(0, 19) == 0)
            send_calm <= $urandom_range(20, 80);
        end
      end
    end
  end

  // event receiver: after a taken item ready stays low for a drawn stall, except in a calm run
  always @(negedge clk) begin
    if (rst) begin
      evt_ch.ready <= 1'b0;
      recv_stall   <= 0;
      recv_calm    <= 0;
    end else if (evt_took) begin
      if (recv_calm > 0) begin
        recv_stall   <= 0;
        evt_ch.ready <= 1'b1;
        recv_calm    <= recv_calm - 1;
      end else begin
        recv_draw     = $urandom_range(0, 17);
        recv_stall   <= recv_draw;
        evt_ch.ready <= (recv_draw == 0);
        if ($urandom_range(0, 19) == 0)
          recv_calm <= $urandom_range(20, 80);
      end
    end else begin
      if (recv_stall > 0)
        recv_stall <= recv_stall - 1;
      evt_ch.ready <= (recv_stall <= 1);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout: %0d events still pending", pending_events.size());
      $display("** four_button_debounce_classifier_core: FAILED **");
      $finish;
    end
  end

  task automatic push_scan(input logic [fbdc_pkg::LEVEL_WIDTH-1:0] lv,
                           input logic [fbdc_pkg::NOW_WIDTH-1:0] now);
    scan_item_t it;
    it.levels = lv;
    it.now_ms = now;
    scan_q.push_back(it);
  endtask

  task automatic write_reg(input logic [fbdc_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [fbdc_pkg::CFG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == fbdc_pkg::REG_DEBOUNCE)
      debounce_ms = val;
    else if (idx == fbdc_pkg::REG_LONG_PRESS)
      long_press_ms = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (scan_q.size() != 0 || scan_ch.valid || pending_events.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly plausible button activity, with boundary hits on the debounce and
  // long-press windows and some wild time jumps
  task automatic push_random(input int count, input logic [fbdc_pkg::CFG_WIDTH-1:0] deb,
                             input logic [fbdc_pkg::CFG_WIDTH-1:0] hold);
    logic [fbdc_pkg::LEVEL_WIDTH-1:0] prev;
    logic [fbdc_pkg::NOW_WIDTH-1:0]   target;
    int r;
    int b;
    for (int n = 0; n < count; n++) begin
      r    = $urandom_range(0, 99);
      prev = gen_lv;
      if (r < 30)
        gen_now += $urandom_range(0, 30);
      else if (r < 58)
        gen_now += $urandom_range(0, 400);
      else if (r < 74)
        gen_now += $urandom_range(0, 2500);
      else if (r < 80)
        gen_now += $urandom_range(0, 140000);
      else if (r < 92) begin
        b = $urandom_range(0, fbdc_pkg::NUM_BUTTONS - 1);
        if (!gen_lv[b])
          target = gen_edge[b] + hold + $urandom_range(0, 2) - 1;
        else
          target = gen_edge[b] + deb + $urandom_range(0, 1);
        if (target - gen_now < 32'h8000_0000)
          gen_now = target;
        gen_lv[b] = ~gen_lv[b];
      end else if (r < 96)
        gen_now = $urandom;
      // remaining draws repeat the same timestamp
      if (r < 80 || r >= 92) begin
        if ($urandom_range(0, 7) == 0)
          gen_lv = fbdc_pkg::LEVEL_WIDTH'($urandom_range(0, 15));
        else
          for (int k = 0; k < fbdc_pkg::NUM_BUTTONS; k++)
            if ($urandom_range(0, 3) == 0)
              gen_lv[k] = ~gen_lv[k];
      end
      for (int k = 0; k < fbdc_pkg::NUM_BUTTONS; k++)
        if (gen_lv[k] != prev[k])
          gen_edge[k] = gen_now;
      push_scan(gen_lv, gen_now);
    end
  endtask

  initial begin
    logic [fbdc_pkg::CFG_WIDTH-1:0] deb_set  [NUM_PHASES];
    logic [fbdc_pkg::CFG_WIDTH-1:0] hold_set [NUM_PHASES];
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = fbdc_pkg::REG_DEBOUNCE;
    cfg_data         = '0;
    cycle_cnt        = 0;
    scans_sent       = 0;
    events_checked   = 0;
    mismatches       = 0;
    settings_used    = 1;
    gen_lv           = '1;
    gen_now          = 32'd3000;
    for (int k = 0; k < fbdc_pkg::NUM_BUTTONS; k++)
      gen_edge[k] = '0;
    for (int k = 0; k < 7; k++)
      event_count[k] = 0;
    deb_set  = '{16'd0, 16'd65535, 16'd0,     16'd65535, 16'd0, 16'd50};
    hold_set = '{16'd0, 16'd65535, 16'd65535, 16'd0,     16'd0, 16'd1000};
    deb_set[4]  = fbdc_pkg::CFG_WIDTH'($urandom_range(1, 300));
    hold_set[4] = fbdc_pkg::CFG_WIDTH'($urandom_range(1, 3000));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed scans under the reset settings
    push_scan(4'hF, 32'd0);          // nothing pressed
    push_scan(4'hE, 32'd50);         // exactly at the debounce window: ignored
    push_scan(4'hE, 32'd51);         // press and any-pressed in one scan
    push_scan(4'hF, 32'd60);         // up short
    push_scan(4'h0, 32'd200);        // all four pressed
    push_scan(4'hF, 32'd300);        // several released, lowest first
    push_scan(4'hF, 32'd301);
    push_scan(4'hF, 32'd302);
    push_scan(4'hF, 32'd303);        // back short
    push_scan(4'h7, 32'd400);
    push_scan(4'hF, 32'd1400);       // hold of exactly the long-press time
    push_scan(4'h7, 32'd1500);
    push_scan(4'hF, 32'd2499);       // one short of long
    push_scan(4'h0, 32'hFFFF_FFF0);
    push_scan(4'h0, 32'hFFFF_FFFF);  // still inside the window after any-pressed
    push_scan(4'hF, 32'd5);          // hold across the time wrap
    push_scan(4'hF, 32'd6);
    push_scan(4'hF, 32'd7);
    push_scan(4'hF, 32'd8);
    push_scan(4'hE, 32'd58);
    push_scan(4'hE, 32'd59);
    push_scan(4'hE, 32'd100);
    push_scan(4'hA, 32'd100);        // up still held, ok pressed too early
    push_scan(4'hF, 32'd200);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(fbdc_pkg::REG_DEBOUNCE, deb_set[ph]);
      write_reg(fbdc_pkg::REG_LONG_PRESS, hold_set[ph]);
      settings_used++;
      if (ph == 1)
        gen_now = 32'hFFFF_E000;
      push_random(PHASE_SCANS / 2, deb_set[ph], hold_set[ph]);
      wait_drained();
      push_random(PHASE_SCANS - PHASE_SCANS / 2, deb_set[ph], hold_set[ph]);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (pending_events.size() != 0) begin
      $display("%0d predicted events never arrived", pending_events.size());
      mismatches++;
    end
    $display("ran %0d scans under %0d register settings, %0d events checked, %0d mismatches",
             scans_sent, settings_used, events_checked, mismatches);
    $display("events: none %0d up %0d down %0d ok %0d back %0d back-long %0d any %0d",
             event_count[fbdc_pkg::EV_NONE], event_count[fbdc_pkg::EV_UP_SHORT],
             event_count[fbdc_pkg::EV_DOWN_SHORT], event_count[fbdc_pkg::EV_OK_SHORT],
             event_count[fbdc_pkg::EV_BACK_SHORT], event_count[fbdc_pkg::EV_BACK_LONG],
             event_count[fbdc_pkg::EV_ANY]);
    if (mismatches == 0)
      $display("** four_button_debounce_classifier_core: PASSED **");
    else
      $display("** four_button_debounce_classifier_core: FAILED **");
    $finish;
  end

endmodule

### four_button_debounce_classifier_core.f
rtl/core/fbdc_pkg.sv
rtl/core/fbdc_channels.sv
rtl/core/fbdc_eval.sv
rtl/core/four_button_debounce_classifier_core.sv
test/four_button_debounce_classifier_core_tb.sv
